// ----- sv/ille_pkg.sv -----
`default_nettype none

package ille_pkg;

    localparam int POS_W  = 9;
    localparam int LEN_W  = 9;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_RDV,
        S_ALLOC,
        S_INS2,
        S_DEL,
        S_DEL2
    } t_state;

    typedef enum logic [1:0] {
        OP_READ,
        OP_INS,
        OP_DEL
    } t_op;

endpackage

`default_nettype wire

// ----- sv/ille_ram.sv -----
`default_nettype none

module ille_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/indexed_linked_list_engine_top.sv -----
`default_nettype none

// Singly linked list of signed values kept in a node memory with a free chain. A command
// word is taken when start is high and busy is low, and exactly one result word follows,
// shown for one cycle with o_strobe; the receiver cannot stall it. After reset the block
// builds the free chain with busy high. A command that needs a walk follows the links
// from the head through the link memory, then reads the value or updates the links;
// commands rejected at once skip the walk.

module indexed_linked_list_engine_top #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ille_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [ille_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [ille_pkg::DATA_W-1:0] i_item_value,
    output logic                                o_strobe,
    output logic signed [ille_pkg::DATA_W-1:0]  o_read_value,
    output logic [ille_pkg::STAT_W-1:0]         o_status,
    output logic [ille_pkg::LEN_W-1:0]          o_list_length
);

    import ille_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_at_head, n_at_head;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_nxt, n_nxt;
    logic [PW-1:0] r_new, n_new;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] r_free, n_free;
    logic [PW-1:0] r_count, n_count;
    logic [PW-1:0] r_clr, n_clr;
    logic signed [VALUE_WIDTH-1:0] r_val, n_val;
    logic r_strobe, n_strobe;
    logic signed [DATA_W-1:0] r_read_value, n_read_value;
    logic [STAT_W-1:0] r_status, n_status;
    logic [LEN_W-1:0] r_len, n_len;

    logic          lk_we;
    logic [AW-1:0] lk_waddr;
    logic [PW-1:0] lk_wdata;
    logic [AW-1:0] lk_raddr;
    logic [PW-1:0] lk_rdata;
    logic [PW-1:0] lk_next;
    logic          vl_we;
    logic [AW-1:0] vl_waddr;
    logic [AW-1:0] vl_raddr;
    logic [VALUE_WIDTH-1:0] vl_rdata;

    logic          accept;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] cnt_x;
    logic [CW-1:0] ins_pos;
    logic [PW-1:0] walk_nx;
    logic [CW-1:0] len_x;

    ille_ram #(.DEPTH(CAPACITY), .AW(AW), .DW(PW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    ille_ram #(.DEPTH(CAPACITY), .AW(AW), .DW(VALUE_WIDTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vl_we),
        .i_waddr (vl_waddr),
        .i_wdata (r_val),
        .i_raddr (vl_raddr),
        .o_rdata (vl_rdata)
    );

    assign lk_next = (lk_rdata > NIL) ? NIL : lk_rdata;
    assign busy    = (r_state != S_IDLE) || !i_rst_n;
    assign accept  = start && (r_state == S_IDLE);
    assign pos_x   = CW'(i_position);
    assign cnt_x   = CW'(r_count);
    assign walk_nx = (r_cur == NIL) ? NIL : lk_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_free   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_op         <= n_op;
        r_at_head    <= n_at_head;
        r_k          <= n_k;
        r_cnt        <= n_cnt;
        r_cur        <= n_cur;
        r_nxt        <= n_nxt;
        r_new        <= n_new;
        r_val        <= n_val;
        r_read_value <= n_read_value;
        r_status     <= n_status;
        r_len        <= n_len;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_at_head    = r_at_head;
        n_k          = r_k;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_new        = r_new;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free       = r_free;
        n_count      = r_count;
        n_clr        = r_clr;
        n_val        = r_val;
        n_strobe     = 1'b0;
        n_read_value = r_read_value;
        n_status     = r_status;
        lk_we        = 1'b0;
        lk_waddr     = r_cur[AW-1:0];
        lk_wdata     = r_nxt;
        lk_raddr     = r_cur[AW-1:0];
        vl_we        = 1'b0;
        vl_waddr     = r_free[AW-1:0];
        vl_raddr     = r_cur[AW-1:0];
        ins_pos      = pos_x;

        unique case (r_state)
            S_CLEAR: begin
                lk_we    = 1'b1;
                lk_waddr = r_clr[AW-1:0];
                lk_wdata = r_clr + PW'(1);
                n_clr    = r_clr + PW'(1);
                if (r_clr == PW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_val     = VALUE_WIDTH'(i_item_value);
                    n_cur     = r_head;
                    n_cnt     = '0;
                    lk_raddr  = r_head[AW-1:0];
                    n_at_head = (pos_x == '0);
                    n_k       = (pos_x == '0) ? '0 : pos_x - CW'(1);
                    unique case (i_cmd)
                        CMD_READ: begin
                            n_op  = OP_READ;
                            n_k   = pos_x;
                            if (pos_x >= cnt_x) begin
                                n_strobe     = 1'b1;
                                n_read_value = -32'sd1;
                                n_status     = ST_RANGE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                            n_op = OP_INS;
                            if (i_cmd == CMD_INS_HEAD) begin
                                ins_pos = '0;
                            end else if (i_cmd == CMD_INS_TAIL) begin
                                ins_pos = cnt_x;
                            end
                            n_at_head    = (ins_pos == '0);
                            n_k          = (ins_pos == '0) ? '0 : ins_pos - CW'(1);
                            n_read_value = '0;
                            if (ins_pos > cnt_x) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else if (r_count >= NIL) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        CMD_DEL_POS: begin
                            n_op         = OP_DEL;
                            n_read_value = '0;
                            if (pos_x >= cnt_x) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_strobe     = 1'b1;
                            n_read_value = '0;
                            n_status     = ST_RANGE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if ((r_cnt == r_k) || (r_cur == NIL)) begin
                    n_status = ST_DONE;
                    unique case (r_op)
                        OP_READ: begin
                            if (r_cur == NIL) begin
                                n_strobe     = 1'b1;
                                n_read_value = -32'sd1;
                                n_status     = ST_RANGE;
                                n_state      = S_IDLE;
                            end else begin
                                vl_raddr = r_cur[AW-1:0];
                                n_state  = S_RDV;
                            end
                        end
                        OP_INS: begin
                            if (!r_at_head && (r_cur == NIL)) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                                n_state  = S_IDLE;
                            end else begin
                                n_nxt    = walk_nx;
                                lk_raddr = r_free[AW-1:0];
                                n_state  = S_ALLOC;
                            end
                        end
                        default: begin
                            if (r_at_head) begin
                                n_head = walk_nx;
                                if (walk_nx == NIL) begin
                                    n_tail = NIL;
                                end
                                if (r_cur != NIL) begin
                                    lk_we    = 1'b1;
                                    lk_waddr = r_cur[AW-1:0];
                                    lk_wdata = r_free;
                                    n_free   = r_cur;
                                end
                                n_count  = r_count - PW'(1);
                                n_strobe = 1'b1;
                                n_state  = S_IDLE;
                            end else if ((r_cur == NIL) || (walk_nx == NIL)) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                                n_state  = S_IDLE;
                            end else begin
                                n_nxt    = walk_nx;
                                lk_raddr = walk_nx[AW-1:0];
                                n_state  = S_DEL;
                            end
                        end
                    endcase
                end else begin
                    n_cur    = lk_next;
                    n_cnt    = r_cnt + CW'(1);
                    lk_raddr = lk_next[AW-1:0];
                end
            end
            S_RDV: begin
                n_read_value = DATA_W'($signed(vl_rdata));
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
            end
            S_ALLOC: begin
                if (r_free == NIL) begin
                    n_strobe = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_free   = lk_next;
                    vl_we    = 1'b1;
                    vl_waddr = r_free[AW-1:0];
                    lk_we    = 1'b1;
                    lk_waddr = r_free[AW-1:0];
                    if (r_at_head) begin
                        lk_wdata = r_head;
                        n_head   = r_free;
                        if (r_head == NIL) begin
                            n_tail = r_free;
                        end
                        n_count  = r_count + PW'(1);
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        lk_wdata = r_nxt;
                        n_new    = r_free;
                        n_state  = S_INS2;
                    end
                end
            end
            S_INS2: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur[AW-1:0];
                lk_wdata = r_new;
                if (r_nxt == NIL) begin
                    n_tail = r_new;
                end
                n_count  = r_count + PW'(1);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_DEL: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur[AW-1:0];
                lk_wdata = lk_next;
                if (lk_next == NIL) begin
                    n_tail = r_cur;
                end
                n_state = S_DEL2;
            end
            S_DEL2: begin
                lk_we    = 1'b1;
                lk_waddr = r_nxt[AW-1:0];
                lk_wdata = r_free;
                n_free   = r_nxt;
                n_count  = r_count - PW'(1);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign len_x = CW'(n_count);
    assign n_len = len_x[LEN_W-1:0];

    assign o_strobe      = r_strobe;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_list_length = r_len;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above capacity");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NIL) == (r_count == '0)))
        else $error("head pointer disagrees with entry count");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_strobe || (r_state != S_IDLE)))
        else $error("accepted command produced no work");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status == ST_FULL)) |-> (r_count == NIL))
        else $error("full status with free nodes left");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
    import ille_pkg::*;

    localparam int CAP       = 256;
    localparam int MAX_CYCLE = 1500000;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       gap;
        bit                       drain;
    } t_word;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         list_length;
    } t_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         i_cmd;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_item_value;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_read_value;
    logic [STAT_W-1:0]        o_status;
    logic [LEN_W-1:0]         o_list_length;

    t_word                    cmd_words[$];
    t_result                  expected_results[$];
    logic signed [DATA_W-1:0] list_values[$];
    t_word                    held_word;
    bit                       holding;
    int                       gap_left;
    int                       mismatches;
    int                       cycles;
    int                       shadow_len;
    bit                       no_idle;

    indexed_linked_list_engine_top #(
        .CAPACITY(CAP),
        .VALUE_WIDTH(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_position(i_position),
        .i_item_value(i_item_value),
        .o_strobe(o_strobe),
        .o_read_value(o_read_value),
        .o_status(o_status),
        .o_list_length(o_list_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result apply_list_cmd(t_word w);
        t_result r;
        int      p;
        r.read_value = '0;
        r.status = ST_DONE;
        case (w.cmd)
            CMD_READ: begin
                if (w.pos < list_values.size()) begin
                    r.read_value = list_values[w.pos];
                end else begin
                    r.read_value = -1;
                    r.status = ST_RANGE;
                end
            end
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                if (w.cmd == CMD_INS_HEAD) begin
                    p = 0;
                end else if (w.cmd == CMD_INS_TAIL) begin
                    p = list_values.size();
                end else begin
                    p = w.pos;
                end
                if (p > list_values.size()) begin
                    r.status = ST_RANGE;
                end else if (list_values.size() >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    list_values.insert(p, w.val);
                end
            end
            CMD_DEL_POS: begin
                if (w.pos >= list_values.size()) begin
                    r.status = ST_RANGE;
                end else begin
                    list_values.delete(w.pos);
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.list_length = LEN_W'(list_values.size());
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic add_word(logic [CMD_W-1:0] cmd, int pos, logic signed [DATA_W-1:0] val);
        t_word w;
        w.cmd = cmd;
        w.pos = POS_W'(pos);
        w.val = val;
        w.gap = no_idle ? 0 : $urandom_range(0, 11);
        w.drain = 1'b0;
        cmd_words.push_back(w);
        if (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL) begin
            if (shadow_len < CAP) shadow_len++;
        end else if (cmd == CMD_INS_POS) begin
            if (pos <= shadow_len && shadow_len < CAP) shadow_len++;
        end else if (cmd == CMD_DEL_POS) begin
            if (pos < shadow_len) shadow_len--;
        end
    endtask

    task automatic add_drain();
        t_word w;
        w.cmd = CMD_READ;
        w.pos = 0;
        w.val = 0;
        w.gap = 0;
        w.drain = 1'b1;
        cmd_words.push_back(w);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -1;
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pos(bit for_insert);
        int lim;
        lim = for_insert ? shadow_len : shadow_len - 1;
        if ($urandom_range(0, 9) < 8 && lim >= 0) return $urandom_range(0, lim);
        return $urandom_range(0, 511);
    endfunction

    always @(posedge i_clk) begin
        bit    go;
        t_word w;
        go = start;
        if (!i_rst_n) begin
            start <= 1'b0;
            holding <= 1'b0;
            gap_left <= 0;
            i_cmd <= '0;
            i_position <= '0;
            i_item_value <= '0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(apply_list_cmd(held_word));
                go = 1'b0;
            end
            if (!go) begin
                if (holding) begin
                    if (gap_left == 0) begin
                        go = 1'b1;
                        holding <= 1'b0;
                    end else begin
                        gap_left <= gap_left - 1;
                    end
                end else if (cmd_words.size() > 0) begin
                    if (cmd_words[0].drain) begin
                        if (expected_results.size() == 0) void'(cmd_words.pop_front());
                    end else begin
                        w = cmd_words.pop_front();
                        held_word <= w;
                        i_cmd <= w.cmd;
                        i_position <= w.pos;
                        i_item_value <= w.val;
                        if (w.gap == 0) begin
                            go = 1'b1;
                        end else begin
                            holding <= 1'b1;
                            gap_left <= w.gap - 1;
                        end
                    end
                end
            end
            start <= go;
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report("unexpected word", o_status, 0);
            end else begin
                e = expected_results.pop_front();
                if (o_read_value !== e.read_value) report("read_value", o_read_value, e.read_value);
                if (o_status !== e.status) report("status", o_status, e.status);
                if (o_list_length !== e.list_length) begin
                    report("list_length", o_list_length, e.list_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLE) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int c;
        int k;
        int bias;
        shadow_len = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;

        add_word(CMD_READ, 0, 0);
        add_word(CMD_DEL_POS, 0, 0);
        add_word(CMD_INS_POS, 1, 5);
        add_word(CMD_INS_HEAD, 0, 32'sh7fffffff);
        add_word(CMD_INS_TAIL, 0, 32'sh80000000);
        add_word(CMD_INS_POS, 0, -1);
        add_word(CMD_INS_POS, 3, 32'sh5a5a5a5a);
        add_word(CMD_INS_POS, 2, 32'sha5a5a5a5);
        add_word(CMD_INS_POS, 9, 1);
        add_word(CMD_READ, 0, 0);
        add_word(CMD_READ, 4, 0);
        add_word(CMD_READ, 5, 0);
        add_word(CMD_READ, 511, 0);
        add_word(CMD_DEL_POS, 511, 0);
        add_word(CMD_INS_POS, 511, 0);
        add_word(3'd5, 0, 1);
        add_word(3'd6, 256, 2);
        add_word(3'd7, 511, 32'shffffffff);
        add_word(CMD_DEL_POS, 4, 0);
        add_word(CMD_DEL_POS, 0, 0);
        add_word(CMD_DEL_POS, 1, 0);
        add_word(CMD_READ, 1, 0);
        add_drain();

        for (k = 0; k < 1000; k++) begin
            if (k % 100 == 0) begin
                bias = $urandom_range(3, 7);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (k == 400) begin
                no_idle = 1'b1;
                while (shadow_len < CAP) add_word(CMD_INS_TAIL, 0, pick_value());
                add_word(CMD_INS_HEAD, 0, 1);
                add_word(CMD_INS_TAIL, 0, 2);
                add_word(CMD_INS_POS, 256, 3);
                add_word(CMD_INS_POS, 257, 4);
                add_word(CMD_INS_POS, 0, 5);
                add_word(CMD_READ, 255, 0);
                add_word(CMD_READ, 256, 0);
                add_word(CMD_DEL_POS, 255, 0);
                add_word(CMD_INS_POS, 255, 6);
                add_word(CMD_DEL_POS, 128, 0);
                add_drain();
            end
            c = $urandom_range(0, 9);
            if (c < bias) begin
                case ($urandom_range(0, 2))
                    0: add_word(CMD_INS_HEAD, $urandom_range(0, 511), pick_value());
                    1: add_word(CMD_INS_TAIL, $urandom_range(0, 511), pick_value());
                    default: add_word(CMD_INS_POS, pick_pos(1'b1), pick_value());
                endcase
            end else if (c < 8) begin
                add_word(CMD_DEL_POS, pick_pos(1'b0), pick_value());
            end else if (c < 9 || $urandom_range(0, 3) != 0) begin
                add_word(CMD_READ, pick_pos(1'b0), pick_value());
            end else begin
                add_word(CMD_W'($urandom_range(5, 7)), $urandom_range(0, 511), pick_value());
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_words.size() > 0 || holding || start || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
